// ===== rtl/sgm_pkg.sv =====
// Shared types and constants for the Sobel gradient magnitude block.
// No dependencies; imported by sgm_sqrt_cell, sobel_gradient_magnitude and sgm_checker.
`default_nettype none

package sgm_pkg;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int LUM_W         = 10;   // a+b+c fits in 10 bits
    localparam int GRAD_W        = 12;   // |dx|, |dy| up to 4*765
    localparam int RAD_W         = 26;   // radicand and root work width
    localparam int ROOT_W        = 13;   // isqrt of 2*3060^2 fits in 13 bits
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_COLOR_MODE   = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] chan_a;
        logic [7:0] chan_b;
        logic [7:0] chan_c;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] gradient;
        logic       last_of_frame;
    } t_grad_out;

    // what travels along the root cells
    typedef struct packed {
        logic             valid;
        logic             color;
        logic             last;
        logic [RAD_W-1:0] rem;
        logic [RAD_W-1:0] root;
    } t_cell_bus;

endpackage

`default_nettype wire

// ===== rtl/sgm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sgm_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sgm_sqrt_cell.sv =====
// One step of the digit-by-digit integer square root, registered.
// Depends on sgm_pkg (t_cell_bus, RAD_W).
`default_nettype none

module sgm_sqrt_cell
    import sgm_pkg::*;
#(
    parameter int BIT_POS = 0
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire t_cell_bus i_bus,
    output t_cell_bus      o_bus
);

    localparam logic [RAD_W-1:0] TRIAL_BIT = RAD_W'(1) << (2 * BIT_POS);

    t_cell_bus n_bus;
    t_cell_bus r_bus;
    logic [RAD_W-1:0] trial;

    always_comb begin
        trial = i_bus.root + TRIAL_BIT;
        n_bus = i_bus;
        if (i_bus.rem >= trial) begin
            n_bus.rem  = i_bus.rem - trial;
            n_bus.root = (i_bus.root >> 1) + TRIAL_BIT;
        end else begin
            n_bus.root = i_bus.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else if (i_en) begin
            r_bus.valid <= n_bus.valid;
        end
        if (i_en) begin
            r_bus.color <= n_bus.color;
            r_bus.last  <= n_bus.last;
            r_bus.rem   <= n_bus.rem;
            r_bus.root  <= n_bus.root;
        end
    end

    assign o_bus = r_bus;

endmodule

`default_nettype wire

// ===== rtl/sobel_gradient_magnitude.sv =====
// Sobel 3x3 gradient magnitude over a raster pixel stream. One pixel per clock is taken
// while the result side does not stall; a result passes the stage registers and then a
// row of square-root cells (one root bit per cell) before it leaves. Border pixels give no result.
// Depends on sgm_pkg, sgm_ram and sgm_sqrt_cell.
`default_nettype none

module sobel_gradient_magnitude
    import sgm_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_pix_in               i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_grad_out                  o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    // configuration
    logic [12:0] r_frame_width;
    logic [15:0] r_frame_height;
    logic        r_color_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 13'd640;
            r_frame_height <= 16'd480;
            r_color_mode   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[12:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_COLOR_MODE:   r_color_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // whole pipe moves together unless a result sits stalled at the output
    logic adv;
    logic accept;
    assign adv        = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv;
    assign accept     = i_in_valid && adv;

    // stage 0: position counters and line store read
    logic [31:0]    w_last_full;
    logic [CW-1:0]  w_last;
    logic [15:0]    h_last;
    logic [CW-1:0]  r_col, n_col;
    logic [15:0]    r_row, n_row;
    logic [LUM_W-1:0] lum;
    logic           row_end;

    always_comb begin
        if (r_frame_width < 13'd3) begin
            w_last_full = 32'd2;
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_last_full = 32'(MAX_WIDTH - 1);
        end else begin
            w_last_full = 32'(r_frame_width) - 32'd1;
        end
        w_last = w_last_full[CW-1:0];
        h_last = (r_frame_height < 16'd3) ? 16'd2 : r_frame_height - 16'd1;
        lum = LUM_W'(i_in_data.chan_a);
        if (r_color_mode) begin
            lum = lum + LUM_W'(i_in_data.chan_b) + LUM_W'(i_in_data.chan_c);
        end
        row_end = (r_col >= w_last);
        if (row_end) begin
            n_col = '0;
            n_row = (r_row >= h_last) ? 16'd0 : r_row + 16'd1;
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage 1 registers
    logic             r_s1_valid;
    logic             r_s1_emit;
    logic             r_s1_last;
    logic             r_s1_color;
    logic [LUM_W-1:0] r_s1_lum;
    logic [CW-1:0]    r_s1_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept;
        end
        if (accept) begin
            r_s1_emit  <= (r_row >= 16'd2) && (r_col >= CW'(2));
            r_s1_last  <= row_end && (r_row >= h_last);
            r_s1_color <= r_color_mode;
            r_s1_lum   <= lum;
            r_s1_col   <= r_col;
        end
    end

    // line stores: upper in the high half, middle in the low half
    logic [2*LUM_W-1:0] ram_rdata;
    logic [LUM_W-1:0]   up, mid;
    assign up  = ram_rdata[2*LUM_W-1:LUM_W];
    assign mid = ram_rdata[LUM_W-1:0];

    sgm_ram #(
        .WIDTH(2 * LUM_W),
        .DEPTH(MAX_WIDTH)
    ) u_lines (
        .i_clk  (i_clk),
        .i_we   (adv && r_s1_valid),
        .i_waddr(r_s1_col),
        .i_wdata({mid, r_s1_lum}),
        .i_re   (accept),
        .i_raddr(r_col),
        .o_rdata(ram_rdata)
    );

    // window: r_win[row][col], column 2 newest
    logic [LUM_W-1:0] r_win [3][3];
    logic             r_s2_valid;
    logic             r_s2_last;
    logic             r_s2_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
            if (r_s1_valid) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r][0] <= r_win[r][1];
                    r_win[r][1] <= r_win[r][2];
                end
                r_win[0][2] <= up;
                r_win[1][2] <= mid;
                r_win[2][2] <= r_s1_lum;
            end
        end
        if (adv) begin
            r_s2_last  <= r_s1_last;
            r_s2_color <= r_s1_color;
        end
    end

    // stage 2: kernel sums and magnitudes
    logic [GRAD_W-1:0] top_sum, bot_sum, left_sum, right_sum;
    logic [GRAD_W-1:0] ax, ay;

    always_comb begin
        top_sum   = GRAD_W'(r_win[0][0]) + (GRAD_W'(r_win[0][1]) << 1) + GRAD_W'(r_win[0][2]);
        bot_sum   = GRAD_W'(r_win[2][0]) + (GRAD_W'(r_win[2][1]) << 1) + GRAD_W'(r_win[2][2]);
        left_sum  = GRAD_W'(r_win[0][0]) + (GRAD_W'(r_win[1][0]) << 1) + GRAD_W'(r_win[2][0]);
        right_sum = GRAD_W'(r_win[0][2]) + (GRAD_W'(r_win[1][2]) << 1) + GRAD_W'(r_win[2][2]);
        ay = (top_sum >= bot_sum) ? top_sum - bot_sum : bot_sum - top_sum;
        ax = (left_sum >= right_sum) ? left_sum - right_sum : right_sum - left_sum;
    end

    logic              r_s3_valid;
    logic              r_s3_last;
    logic              r_s3_color;
    logic [GRAD_W-1:0] r_ax, r_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s3_valid <= r_s2_valid;
        end
        if (adv) begin
            r_s3_last  <= r_s2_last;
            r_s3_color <= r_s2_color;
            r_ax       <= ax;
            r_ay       <= ay;
        end
    end

    // stage 3: squares into the root chain
    t_cell_bus r_s4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4.valid <= 1'b0;
        end else if (adv) begin
            r_s4.valid <= r_s3_valid;
        end
        if (adv) begin
            r_s4.color <= r_s3_color;
            r_s4.last  <= r_s3_last;
            r_s4.rem   <= RAD_W'(r_ax * r_ax) + RAD_W'(r_ay * r_ay);
            r_s4.root  <= '0;
        end
    end

    // root cells, highest bit first
    t_cell_bus chain [ROOT_W+1];
    assign chain[0] = r_s4;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
        sgm_sqrt_cell #(
            .BIT_POS(ROOT_W - 1 - k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (adv),
            .i_bus  (chain[k]),
            .o_bus  (chain[k+1])
        );
    end

    // rounding: floor((s+2)/4) or floor((s+6)/12), saturated
    t_cell_bus         fin;
    logic [ROOT_W-1:0] s;
    logic [ROOT_W:0]   q4;
    logic [ROOT_W-2:0] n12;
    logic [ROOT_W+16:0] prod;
    logic [ROOT_W:0]   g;
    t_grad_out         n_out;

    always_comb begin
        fin  = chain[ROOT_W];
        s    = fin.root[ROOT_W-1:0];
        q4   = (ROOT_W+1)'(s) + (ROOT_W+1)'(fin.color ? 6 : 2);
        n12  = q4[ROOT_W:2];
        // n/3 as n*43691 >> 17, exact over this range
        prod = (ROOT_W+17)'(n12) * (ROOT_W+17)'(43691);
        g    = fin.color ? (ROOT_W+1)'(prod[ROOT_W+16:17]) : (ROOT_W+1)'(n12);
        n_out.gradient      = (g > (ROOT_W+1)'(255)) ? 8'd255 : g[7:0];
        n_out.last_of_frame = fin.last;
    end

    logic      r_out_valid;
    t_grad_out r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= fin.valid;
        end
        if (adv) begin
            r_out_data <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/sgm_checker.sv =====
// Port-level checks for sobel_gradient_magnitude, bound to the top level.
// Depends on sgm_pkg.
`default_nettype none

module sgm_checker
    import sgm_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_grad_out o_out_data,
    input wire logic      o_cfg_ready
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_stall_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall without a stalled result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind sobel_gradient_magnitude sgm_checker u_sgm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data),
    .o_cfg_ready(o_cfg_ready)
);

`default_nettype wire
